// ===== rtl/code39_bar_encoder_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Code 39 bar encoder unit
// Shared property templates used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef CODE39_BAR_ENCODER_UNIT_ASSERT_SVH
`define CODE39_BAR_ENCODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CBE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CBE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// Code 39 bar encoder package
// Payload types, queue entry, configuration bundle and the symbol tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cbe_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [5:0] STAR_IDX    = 6'd43;
   localparam logic [5:0] INVALID_IDX = 6'd63;
   localparam logic [3:0] ELEM_LAST   = 4'd8;
   localparam logic [3:0] GAP_WIDTH   = 4'd1;

   localparam logic [3:0] WIDE_RESET   = 4'd3;
   localparam logic [3:0] NARROW_RESET = 4'd1;

   localparam logic CSR_WIDE_WIDTH   = 1'b0;
   localparam logic CSR_NARROW_WIDTH = 1'b1;

   typedef struct packed {
      logic [7:0] symbol;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic       is_bar;
      logic [3:0] width;
      logic       bad_symbol;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [3:0] wide_width;
      logic [3:0] narrow_width;
   } cfg_type;

   // One classified character waiting for the element sequencer.
   typedef struct packed {
      logic [5:0] idx;
      logic       bad;
      logic       need_start;
      logic       eom;
   } entry_type;

   // Maps an ASCII code to its pattern index; INVALID_IDX when not encodable.
   function automatic logic [5:0] char_index(input logic [7:0] sym);
      logic [5:0] idx;
      idx = INVALID_IDX;
      if (sym >= 8'h30 && sym <= 8'h39) begin
         idx = 6'(sym - 8'h30);
      end else if (sym >= 8'h41 && sym <= 8'h5A) begin
         idx = 6'(sym - 8'h37);
      end else begin
         case (sym)
            8'h2D: idx = 6'd36;
            8'h2E: idx = 6'd37;
            8'h20: idx = 6'd38;
            8'h24: idx = 6'd39;
            8'h2F: idx = 6'd40;
            8'h2B: idx = 6'd41;
            8'h25: idx = 6'd42;
            default: idx = INVALID_IDX;
         endcase
      end
      return idx;
   endfunction

   // Nine-element pattern, element 0 in the top bit; a 1 marks a wide element.
   function automatic logic [8:0] pattern(input logic [5:0] idx);
      logic [8:0] p;
      case (idx)
         6'd0:  p = 9'b000110100;
         6'd1:  p = 9'b100100001;
         6'd2:  p = 9'b001100001;
         6'd3:  p = 9'b101100000;
         6'd4:  p = 9'b000110001;
         6'd5:  p = 9'b100110000;
         6'd6:  p = 9'b001110000;
         6'd7:  p = 9'b000100101;
         6'd8:  p = 9'b100100100;
         6'd9:  p = 9'b001100100;
         6'd10: p = 9'b100001001;
         6'd11: p = 9'b001001001;
         6'd12: p = 9'b101001000;
         6'd13: p = 9'b000011001;
         6'd14: p = 9'b100011000;
         6'd15: p = 9'b001011000;
         6'd16: p = 9'b000001101;
         6'd17: p = 9'b100001100;
         6'd18: p = 9'b001001100;
         6'd19: p = 9'b000011100;
         6'd20: p = 9'b100000011;
         6'd21: p = 9'b001000011;
         6'd22: p = 9'b101000010;
         6'd23: p = 9'b000010011;
         6'd24: p = 9'b100010010;
         6'd25: p = 9'b001010010;
         6'd26: p = 9'b000000111;
         6'd27: p = 9'b100000110;
         6'd28: p = 9'b001000110;
         6'd29: p = 9'b000010110;
         6'd30: p = 9'b110000001;
         6'd31: p = 9'b011000001;
         6'd32: p = 9'b111000000;
         6'd33: p = 9'b010010001;
         6'd34: p = 9'b110010000;
         6'd35: p = 9'b011010000;
         6'd36: p = 9'b010000101;
         6'd37: p = 9'b110000100;
         6'd38: p = 9'b011000100;
         6'd39: p = 9'b010101000;
         6'd40: p = 9'b010100010;
         6'd41: p = 9'b010001010;
         6'd42: p = 9'b000101010;
         6'd43: p = 9'b010010100;
         default: p = 9'b000000000;
      endcase
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/code39_bar_encoder_unit.sv =====
// Code 39 bar encoder unit: each accepted character becomes a stream of bar and
// space elements, one element per cycle on the response channel while it is not
// stalled. A character yields nine elements and a one-module gap; the first
// character of a message adds the start symbol and gap, and a character marked
// end of message adds the stop symbol. A bad character yields a single response.
// The element sequencer produces one element per cycle unless the response
// channel stalls; a two-entry queue lets the next character be accepted while
// the current one is still being emitted.
// ----------------------------------------------------------------------------
// Code 39 bar encoder unit
// Top level: configuration registers, front end, entry queue and sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module code39_bar_encoder_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cbe_pkg::req_type req_payload,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output cbe_pkg::rsp_type      rsp_payload,
   input  wire logic             csr_write_enable,
   input  wire logic             csr_index,
   input  wire logic [3:0]       csr_data
);

   cbe_pkg::cfg_type   cfg_ff, cfg_in;
   logic               q_push, q_full, q_pop, q_valid;
   cbe_pkg::entry_type q_entry, q_head;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            cbe_pkg::CSR_WIDE_WIDTH:   cfg_in.wide_width   = csr_data;
            cbe_pkg::CSR_NARROW_WIDTH: cfg_in.narrow_width = csr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wide_width   <= cbe_pkg::WIDE_RESET;
         cfg_ff.narrow_width <= cbe_pkg::NARROW_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cbe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_entry)
   );

   cbe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_data  (q_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head       (q_head)
   );

   cbe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_valid     (q_valid),
      .q_head      (q_head),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ===== rtl/cbe_queue.sv =====
// ----------------------------------------------------------------------------
// Code 39 bar encoder entry queue
// Short FIFO of classified characters between the front and the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbe_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire cbe_pkg::entry_type push_data,
   output logic                    full,
   input  wire logic               pop,
   output logic                    head_valid,
   output cbe_pkg::entry_type      head
);

   cbe_pkg::entry_type                 mem_ff [cbe_pkg::QUEUE_DEPTH];
   logic [cbe_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cbe_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cbe_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;

   assign full       = (count_ff == cbe_pkg::QUEUE_CNT_W'(cbe_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == cbe_pkg::QUEUE_PTR_W'(cbe_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == cbe_pkg::QUEUE_PTR_W'(cbe_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cbe_front.sv =====
// ----------------------------------------------------------------------------
// Code 39 bar encoder front end
// Accepts characters, classifies them and tracks whether a message is open.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbe_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire cbe_pkg::req_type req_payload,
   input  wire logic             q_full,
   output logic                  q_push,
   output cbe_pkg::entry_type    q_entry
);

   logic       message_open_ff, message_open_in;
   logic [5:0] idx;

   assign req_ready = !q_full;
   assign q_push    = req_valid && req_ready;

   always_comb begin
      idx                = cbe_pkg::char_index(req_payload.symbol);
      q_entry.idx        = idx;
      q_entry.bad        = (idx == cbe_pkg::INVALID_IDX);
      q_entry.need_start = !message_open_ff;
      q_entry.eom        = req_payload.end_of_message;

      // A bad character leaves the message state alone.
      message_open_in = message_open_ff;
      if (q_push && !q_entry.bad) begin
         message_open_in = !req_payload.end_of_message;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         message_open_ff <= 1'b0;
      end else begin
         message_open_ff <= message_open_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/cbe_back.sv =====
// ----------------------------------------------------------------------------
// Code 39 bar encoder element sequencer
// Walks each queued character through start, gaps, symbol and stop elements or one bad response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cbe_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cbe_pkg::cfg_type   cfg,
   input  wire logic               q_valid,
   input  wire cbe_pkg::entry_type q_head,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output cbe_pkg::rsp_type        rsp_payload
);

   typedef enum logic [6:0] {
      PH_IDLE  = 7'b0000001,
      PH_BAD   = 7'b0000010,
      PH_START = 7'b0000100,
      PH_GAP1  = 7'b0001000,
      PH_CHAR  = 7'b0010000,
      PH_GAP2  = 7'b0100000,
      PH_STOP  = 7'b1000000
   } phase_type;

   phase_type          phase_ff, phase_in;
   logic [3:0]         cnt_ff, cnt_in;
   cbe_pkg::entry_type ent_ff, ent_in;
   logic               rsp_valid_ff, rsp_valid_in;
   cbe_pkg::rsp_type   rsp_data_ff, rsp_data_in;

   phase_type          cur_phase, next_phase;
   cbe_pkg::entry_type cur_ent;
   logic [3:0]         cur_cnt, next_cnt;
   logic               idle, fire, elem_wide;
   logic [8:0]         pat;
   logic [3:0]         width_sel;
   cbe_pkg::rsp_type   res;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   always_comb begin
      idle = (phase_ff == PH_IDLE);

      // When idle, the head of the queue is worked on directly so no cycle is lost.
      if (idle) begin
         cur_ent = q_head;
         cur_cnt = '0;
         if (q_head.bad) begin
            cur_phase = PH_BAD;
         end else if (q_head.need_start) begin
            cur_phase = PH_START;
         end else begin
            cur_phase = PH_CHAR;
         end
      end else begin
         cur_ent   = ent_ff;
         cur_cnt   = cnt_ff;
         cur_phase = phase_ff;
      end

      fire  = (!idle || q_valid) && (!rsp_valid_ff || rsp_ready);
      q_pop = fire && idle;

      pat       = cbe_pkg::pattern((cur_phase == PH_CHAR) ? cur_ent.idx : cbe_pkg::STAR_IDX);
      elem_wide = pat[cbe_pkg::ELEM_LAST - cur_cnt];
      width_sel = elem_wide ? cfg.wide_width : cfg.narrow_width;

      res        = '0;
      next_phase = cur_phase;
      next_cnt   = cur_cnt + 1'b1;

      case (cur_phase)
         PH_BAD: begin
            res.bad_symbol = 1'b1;
            res.last       = 1'b1;
            next_phase     = PH_IDLE;
            next_cnt       = '0;
         end
         PH_START: begin
            res.is_bar = ~cur_cnt[0];
            res.width  = width_sel;
            if (cur_cnt == cbe_pkg::ELEM_LAST) begin
               next_phase = PH_GAP1;
               next_cnt   = '0;
            end
         end
         PH_GAP1: begin
            res.width  = cbe_pkg::GAP_WIDTH;
            next_phase = PH_CHAR;
            next_cnt   = '0;
         end
         PH_CHAR: begin
            res.is_bar = ~cur_cnt[0];
            res.width  = width_sel;
            if (cur_cnt == cbe_pkg::ELEM_LAST) begin
               next_phase = PH_GAP2;
               next_cnt   = '0;
            end
         end
         PH_GAP2: begin
            res.width  = cbe_pkg::GAP_WIDTH;
            res.last   = !cur_ent.eom;
            next_phase = cur_ent.eom ? PH_STOP : PH_IDLE;
            next_cnt   = '0;
         end
         PH_STOP: begin
            res.is_bar = ~cur_cnt[0];
            res.width  = width_sel;
            if (cur_cnt == cbe_pkg::ELEM_LAST) begin
               res.last   = 1'b1;
               next_phase = PH_IDLE;
               next_cnt   = '0;
            end
         end
         default: begin
            next_phase = PH_IDLE;
            next_cnt   = '0;
         end
      endcase

      phase_in     = fire ? next_phase : phase_ff;
      cnt_in       = fire ? next_cnt : cnt_ff;
      ent_in       = q_pop ? q_head : ent_ff;
      rsp_data_in  = fire ? res : rsp_data_ff;
      rsp_valid_in = fire ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff      <= ent_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== rtl/cbe_checker.sv =====
// ----------------------------------------------------------------------------
// Code 39 bar encoder port checker
// Watches the response port of the top level and is bound to it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "code39_bar_encoder_unit_assert.svh"

module cbe_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire cbe_pkg::rsp_type rsp_payload
);

   // A bad character closes its transaction in a single zero-width space.
   `CBE_ASSERT_NOW(a_bad_is_single, clock, reset, rsp_valid && rsp_payload.bad_symbol, rsp_payload.last && rsp_payload.width == 4'd0 && !rsp_payload.is_bar, "bad symbol response malformed")

   `CBE_ASSERT_NOW(a_bar_not_bad, clock, reset, rsp_valid && rsp_payload.is_bar, !rsp_payload.bad_symbol, "bar element flagged as bad")

   `CBE_ASSERT_NEXT(a_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")

   `CBE_ASSERT_NEXT(a_payload_holds, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_payload), "response changed while stalled")

endmodule

bind code39_bar_encoder_unit cbe_checker u_cbe_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

// ===== dv/code39_bar_encoder_unit_checker.sv =====
// ----------------------------------------------------------------------------
// Code 39 bar encoder response checker
// Watches the request, response and register ports of the encoder, predicts
// the bar and space elements of every accepted character and compares each
// accepted response against the oldest predicted element.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module code39_bar_encoder_unit_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  cbe_pkg::req_type          req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  cbe_pkg::rsp_type          rsp_payload,
   input  logic                      csr_write_enable,
   input  logic                      csr_index,
   input  logic [3:0]                csr_data,
   output int                        mismatch_count,
   output int                        outstanding
);

   localparam int NO_SLOT     = -1;
   localparam int STAR_SLOT   = 43;
   localparam int MAX_REPORTS = 10;

   logic [3:0]       wide_modules;
   logic [3:0]       narrow_modules;
   logic             message_started;
   cbe_pkg::rsp_type pending_elements[$];

   // Position of an ASCII code in the Code 39 character set.
   function automatic int charset_slot(input logic [7:0] code);
      string chars;
      int    slot;
      chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-. $/+%";
      slot  = NO_SLOT;
      for (int i = 0; i < chars.len(); i++) begin
         if (slot == NO_SLOT && chars[i] == code) begin
            slot = i;
         end
      end
      return slot;
   endfunction

   // Wide and narrow sequence of the nine elements of a symbol.
   function automatic string bar_pattern(input int slot);
      string p;
      case (slot)
         0:  p = "nnnwwnwnn";
         1:  p = "wnnwnnnnw";
         2:  p = "nnwwnnnnw";
         3:  p = "wnwwnnnnn";
         4:  p = "nnnwwnnnw";
         5:  p = "wnnwwnnnn";
         6:  p = "nnwwwnnnn";
         7:  p = "nnnwnnwnw";
         8:  p = "wnnwnnwnn";
         9:  p = "nnwwnnwnn";
         10: p = "wnnnnwnnw";
         11: p = "nnwnnwnnw";
         12: p = "wnwnnwnnn";
         13: p = "nnnnwwnnw";
         14: p = "wnnnwwnnn";
         15: p = "nnwnwwnnn";
         16: p = "nnnnnwwnw";
         17: p = "wnnnnwwnn";
         18: p = "nnwnnwwnn";
         19: p = "nnnnwwwnn";
         20: p = "wnnnnnnww";
         21: p = "nnwnnnnww";
         22: p = "wnwnnnnwn";
         23: p = "nnnnwnnww";
         24: p = "wnnnwnnwn";
         25: p = "nnwnwnnwn";
         26: p = "nnnnnnwww";
         27: p = "wnnnnnwwn";
         28: p = "nnwnnnwwn";
         29: p = "nnnnwnwwn";
         30: p = "wwnnnnnnw";
         31: p = "nwwnnnnnw";
         32: p = "wwwnnnnnn";
         33: p = "nwnnwnnnw";
         34: p = "wwnnwnnnn";
         35: p = "nwwnwnnnn";
         36: p = "nwnnnnwnw";
         37: p = "wwnnnnwnn";
         38: p = "nwwnnnwnn";
         39: p = "nwnwnwnnn";
         40: p = "nwnwnnnwn";
         41: p = "nwnnnwnwn";
         42: p = "nnnwnwnwn";
         43: p = "nwnnwnwnn";
         default: p = "nnnnnnnnn";
      endcase
      return p;
   endfunction

   task automatic append_element(input cbe_pkg::rsp_type e);
      pending_elements.insert(pending_elements.size(), e);
   endtask

   task automatic queue_symbol(input int slot);
      string            p;
      cbe_pkg::rsp_type e;
      p = bar_pattern(slot);
      for (int i = 0; i < 9; i++) begin
         e.is_bar     = (i % 2 == 0);
         e.width      = (p[i] == "w") ? wide_modules : narrow_modules;
         e.bad_symbol = 1'b0;
         e.last       = 1'b0;
         append_element(e);
      end
   endtask

   task automatic queue_gap();
      cbe_pkg::rsp_type e;
      e.is_bar     = 1'b0;
      e.width      = 4'd1;
      e.bad_symbol = 1'b0;
      e.last       = 1'b0;
      append_element(e);
   endtask

   task automatic predict_elements(input cbe_pkg::req_type txn);
      int               slot;
      cbe_pkg::rsp_type e;
      slot = charset_slot(txn.symbol);
      if (slot == NO_SLOT) begin
         // An unencodable character leaves the message state untouched.
         e.is_bar     = 1'b0;
         e.width      = 4'd0;
         e.bad_symbol = 1'b1;
         e.last       = 1'b1;
         append_element(e);
      end else begin
         if (!message_started) begin
            queue_symbol(STAR_SLOT);
            queue_gap();
         end
         queue_symbol(slot);
         queue_gap();
         if (txn.end_of_message) begin
            queue_symbol(STAR_SLOT);
            message_started = 1'b0;
         end else begin
            message_started = 1'b1;
         end
         e = pending_elements.pop_back();
         e.last = 1'b1;
         append_element(e);
      end
   endtask

   task automatic check_element(input cbe_pkg::rsp_type got);
      cbe_pkg::rsp_type want;
      if (pending_elements.size() == 0) begin
         if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: unexpected response bar=%0d width=%0d bad=%0d last=%0d",
                     $realtime, got.is_bar, got.width, got.bad_symbol, got.last);
         end
         mismatch_count = mismatch_count + 1;
      end else begin
         want = pending_elements.pop_front();
         if (got.is_bar !== want.is_bar || got.width !== want.width ||
             got.bad_symbol !== want.bad_symbol || got.last !== want.last) begin
            if (mismatch_count < MAX_REPORTS) begin
               $display("%0t: response mismatch, expected bar=%0d width=%0d bad=%0d last=%0d",
                        $realtime, want.is_bar, want.width, want.bad_symbol, want.last);
               $display("%0t:                        got bar=%0d width=%0d bad=%0d last=%0d",
                        $realtime, got.is_bar, got.width, got.bad_symbol, got.last);
            end
            mismatch_count = mismatch_count + 1;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         wide_modules    = cbe_pkg::WIDE_RESET;
         narrow_modules  = cbe_pkg::NARROW_RESET;
         message_started = 1'b0;
         mismatch_count  = 0;
         pending_elements.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == cbe_pkg::CSR_WIDE_WIDTH) begin
               wide_modules = csr_data;
            end else begin
               narrow_modules = csr_data;
            end
         end
         // Responses are matched before the new character is predicted, so a
         // response cannot be paired with a transaction accepted at the same edge.
         if (rsp_valid && rsp_ready) begin
            check_element(rsp_payload);
         end
         if (req_valid && req_ready) begin
            predict_elements(req_payload);
         end
      end
      outstanding = pending_elements.size();
   end

endmodule

// ===== dv/code39_bar_encoder_unit_test.sv =====
// ----------------------------------------------------------------------------
// Code 39 bar encoder unit testbench
// Drives directed and random message characters through the encoder under
// several width settings, with random stalls on both channels, and relies on
// the response checker for the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module code39_bar_encoder_unit_test;

   localparam int CYCLE_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 50;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   cbe_pkg::req_type req_payload;
   logic             rsp_valid;
   logic             rsp_ready;
   cbe_pkg::rsp_type rsp_payload;
   logic             csr_write_enable;
   logic             csr_index;
   logic [3:0]       csr_data;

   int   mismatch_count;
   int   outstanding;
   int   cycle_count;
   int   stall_left;
   logic idling_on;
   int   items_sent;

   code39_bar_encoder_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   code39_bar_encoder_unit_checker element_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .outstanding      (outstanding)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count = cycle_count + 1;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Response side: random stall bursts while idling is on.
   initial begin
      rsp_ready  = 1'b0;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready  = 1'b0;
            stall_left = stall_left - 1;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ready  = 1'b0;
            stall_left = $urandom_range(1, 16) - 1;
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   function automatic logic [7:0] random_code39_char();
      string chars;
      chars = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ-. $/+%";
      return chars[$urandom_range(0, 42)];
   endfunction

   task automatic send_char(input logic [7:0] symbol, input logic eom);
      @(negedge clock);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 16)) @(negedge clock);
      end
      req_valid                  = 1'b1;
      req_payload.symbol         = symbol;
      req_payload.end_of_message = eom;
      do @(posedge clock); while (!req_ready);
      items_sent = items_sent + 1;
   endtask

   // Registers change only once the encoder has nothing left to emit.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [3:0] value);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = index;
      csr_data         = value;
      @(negedge clock);
      csr_write_enable = 1'b0;
   endtask

   // A well-formed message with random content, sometimes broken by a stray
   // byte or by a missing end of message.
   task automatic send_message(input logic allow_idling);
      int   length;
      logic drop_stop;
      logic [7:0] symbol;
      length    = $urandom_range(1, 8);
      drop_stop = ($urandom_range(0, 7) == 0);
      idling_on = allow_idling && ($urandom_range(0, 4) != 0);
      for (int k = 0; k < length; k++) begin
         if ($urandom_range(0, 9) == 0) begin
            symbol = 8'($urandom_range(0, 255));
         end else begin
            symbol = random_code39_char();
         end
         if (k == length - 1) begin
            send_char(symbol, !drop_stop);
         end else begin
            send_char(symbol, $urandom_range(0, 15) == 0);
         end
      end
   endtask

   initial begin
      logic [3:0] wide_value;
      logic [3:0] narrow_value;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_index        = cbe_pkg::CSR_WIDE_WIDTH;
      csr_data         = 4'd0;
      idling_on        = 1'b0;
      items_sent       = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed characters at the reset widths.
      idling_on = 1'b1;
      send_char("0", 1'b0);
      send_char("Z", 1'b0);
      send_char("*", 1'b0);
      send_char("-", 1'b0);
      send_char(".", 1'b0);
      send_char(" ", 1'b0);
      send_char(8'h00, 1'b1);
      send_char("$", 1'b0);
      send_char("/", 1'b0);
      send_char("+", 1'b0);
      send_char(8'hFF, 1'b0);
      send_char(8'hC1, 1'b1);
      send_char("%", 1'b1);
      send_char("9", 1'b1);
      send_char("*", 1'b1);
      send_char("a", 1'b0);
      send_char(8'h80, 1'b0);
      send_char(8'h7F, 1'b1);
      send_char("A", 1'b0);
      send_char(8'hAA, 1'b1);
      send_char("M", 1'b1);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin wide_value = 4'd15; narrow_value = 4'd1;  end
            1: begin wide_value = 4'd1;  narrow_value = 4'd15; end
            2: begin wide_value = 4'd0;  narrow_value = 4'd0;  end
            3: begin wide_value = 4'd15; narrow_value = 4'd15; end
            4: begin wide_value = 4'd0;  narrow_value = 4'd15; end
            default: begin
               wide_value   = 4'($urandom_range(0, 15));
               narrow_value = 4'($urandom_range(0, 15));
            end
         endcase
         write_csr(cbe_pkg::CSR_WIDE_WIDTH, wide_value);
         write_csr(cbe_pkg::CSR_NARROW_WIDTH, narrow_value);
         items_sent = 0;
         while (items_sent < ITEMS_PER_PHASE) begin
            send_message(phase != RANDOM_PHASES - 1);
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
